[design/jddm_pkg.sv]
// jddm_pkg: shared types and constants of the joystick differential drive mixer
// used by the top level and by its port checker; no dependencies

package jddm_pkg;

  // drive mode codes as they appear on the result tuser
  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_SPIN  = 2'd1,
    MODE_DRIVE = 2'd2
  } drive_mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEADZONE_FWD   = 3'd0,
    REG_DEADZONE_TURN  = 3'd1,
    REG_DRIVE_DUTY_MIN = 3'd2,
    REG_DRIVE_DUTY_MAX = 3'd3,
    REG_SPIN_DUTY_MIN  = 3'd4,
    REG_SPIN_DUTY_MAX  = 3'd5,
    REG_STEER_SPAN     = 3'd6
  } reg_idx_e;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  // offset divider: three radix 2^16 digits of the offset magnitude
  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIG_W     = 16;
  localparam int unsigned DVD_W     = DIV_STEPS * DIG_W;

  // 0.3 in q16
  localparam logic [14:0] Q16_POINT3 = 15'd19661;
  localparam logic signed [28:0] Q16_ONE = 29'sd65536;

  // bridge levels and mode of one beat
  typedef struct packed {
    drive_mode_e mode;
    logic        la;
    logic        lb;
    logic        ra;
    logic        rb;
  } ctl_t;

  // payload of the offset divider stages
  typedef struct packed {
    logic [14:0]        rem;
    logic [DVD_W-1:0]   quo;
    logic [DVD_W-1:0]   dvd;
    logic signed [47:0] base;
    logic               neg;
    ctl_t               ctl;
  } div_t;

endpackage

[design/joystick_differential_drive_mixer_top.sv]
// joystick differential drive mixer: input register, q16 scale by reciprocal,
// squared curve, steering factor and a pipelined constant divider; uses jddm_pkg
//
// Usage:
//   s_axis carries one pair of joystick samples per beat (fwd axis, turn axis).
//   m_axis returns one result beat per input beat: both motor duties, the four
//   bridge levels in tdata and the drive mode in tuser.
//   cfg_* writes one mixer register per cycle; write only while no beat is in
//   flight. Indexes past the register list are ignored.
// Pipeline:
//   throughput is one beat per cycle while m_axis_tready does not stall the
//   pipeline; every stage holds at most one beat, the work is split over 13
//   register stages (entry, reciprocal estimate, correction, squares, curve
//   and steering products, rounding, two stages for each of three divider
//   digits, then clamp into the output register).
// Reset:
//   clears all stage valid bits and loads the register defaults
//   (deadzones 100, drive duty 300..1000, spin duty 400..700, steer span 400).
// Stall:
//   with m_axis_tready low and a result waiting, the whole pipeline holds and
//   s_axis_tready drops in the same cycle; nothing is lost or repeated.

module joystick_differential_drive_mixer_top
  import jddm_pkg::*;
#(
  parameter int FWD_CENTER  = 2048,
  parameter int TURN_CENTER = 2048
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [11:0] sample_fwd, [23:12] sample_turn
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [15:0] duty_left, [31:16] duty_right, [32] left_pin_a, [33] left_pin_b,
  // [34] right_pin_a, [35] right_pin_b, [39:36] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] drive_mode
  output logic [1:0]             m_axis_tuser_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  // reciprocals floor(2^32 / centre); estimate is exact or one low
  localparam logic [32:0] RecipF = 33'((64'd1 << 32) / FWD_CENTER);
  localparam logic [32:0] RecipT = 33'((64'd1 << 32) / TURN_CENTER);
  localparam logic [15:0] CtrF   = 16'(FWD_CENTER);
  localparam logic [15:0] CtrT   = 16'(TURN_CENTER);

  // ---------------------------------------------------------------- registers
  logic [11:0] dz_fwd_q, dz_turn_q;
  logic [15:0] drv_min_q, drv_max_q, spn_min_q, spn_max_q, steer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_fwd_q  <= 12'd100;
      dz_turn_q <= 12'd100;
      drv_min_q <= 16'd300;
      drv_max_q <= 16'd1000;
      spn_min_q <= 16'd400;
      spn_max_q <= 16'd700;
      steer_q   <= 16'd400;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEADZONE_FWD:   dz_fwd_q  <= cfg_wdata_i[11:0];
        REG_DEADZONE_TURN:  dz_turn_q <= cfg_wdata_i[11:0];
        REG_DRIVE_DUTY_MIN: drv_min_q <= cfg_wdata_i;
        REG_DRIVE_DUTY_MAX: drv_max_q <= cfg_wdata_i;
        REG_SPIN_DUTY_MIN:  spn_min_q <= cfg_wdata_i;
        REG_SPIN_DUTY_MAX:  spn_max_q <= cfg_wdata_i;
        REG_STEER_SPAN:     steer_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic adv;
  logic out_vld_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------------------------------------------------------- stage 1
  logic signed [16:0] df, dt;
  logic [15:0]        abs_f, abs_t;
  logic               nz_f, nz_t;
  ctl_t               ctl1_d;

  always_comb begin
    df    = $signed(17'(FWD_CENTER)) - $signed({5'b0, s_axis_tdata_i[11:0]});
    dt    = $signed(17'(TURN_CENTER)) - $signed({5'b0, s_axis_tdata_i[23:12]});
    abs_f = df[16] ? 16'(-df) : df[15:0];
    abs_t = dt[16] ? 16'(-dt) : dt[15:0];
    nz_f  = (df != '0) && !(abs_f < {4'b0, dz_fwd_q});
    nz_t  = (dt != '0) && !(abs_t < {4'b0, dz_turn_q});
    ctl1_d = '{mode: MODE_STOP, la: 1'b0, lb: 1'b0, ra: 1'b0, rb: 1'b0};
    if (nz_f) begin
      ctl1_d.mode = MODE_DRIVE;
      ctl1_d.la   = !df[16];
      ctl1_d.ra   = !df[16];
      ctl1_d.lb   = df[16];
      ctl1_d.rb   = df[16];
    end else if (nz_t) begin
      ctl1_d.mode = MODE_SPIN;
      ctl1_d.la   = !dt[16];
      ctl1_d.rb   = !dt[16];
      ctl1_d.lb   = dt[16];
      ctl1_d.ra   = dt[16];
    end
  end

  logic               s1_vld_q;
  ctl_t               s1_ctl_q;
  logic [15:0]        s1_mag_q;
  logic               s1_turn_q;
  logic signed [16:0] s1_dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q  <= ctl1_d;
      s1_mag_q  <= nz_f ? abs_f : abs_t;
      s1_turn_q <= !nz_f;
      s1_dt_q   <= nz_t ? dt : '0;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // scale estimate: floor(mag * 2^16 * recip / 2^32)
  logic [48:0]        sc_prod;
  logic signed [33:0] dtspan_d;

  assign sc_prod  = {33'b0, s1_mag_q} * {16'b0, (s1_turn_q ? RecipT : RecipF)};
  assign dtspan_d = s1_dt_q * $signed({1'b0, steer_q});

  logic               s2_vld_q;
  ctl_t               s2_ctl_q;
  logic [15:0]        s2_mag_q;
  logic               s2_turn_q;
  logic [27:0]        s2_est_q;
  logic signed [33:0] s2_dtspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ctl_q    <= s1_ctl_q;
      s2_mag_q    <= s1_mag_q;
      s2_turn_q   <= s1_turn_q;
      s2_est_q    <= sc_prod[43:16];
      s2_dtspan_q <= dtspan_d;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [15:0] ctr_sel;
  logic [47:0] sc_rem;
  logic [27:0] sc_d;

  always_comb begin
    ctr_sel = s2_turn_q ? CtrT : CtrF;
    sc_rem  = {16'b0, s2_mag_q, 16'b0} - ({20'b0, s2_est_q} * {32'b0, ctr_sel});
    sc_d    = (sc_rem >= {32'b0, ctr_sel}) ? s2_est_q + 28'd1 : s2_est_q;
  end

  logic               s3_vld_q;
  ctl_t               s3_ctl_q;
  logic [27:0]        s3_sc_q;
  logic signed [33:0] s3_dtspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ctl_q    <= s2_ctl_q;
      s3_sc_q     <= sc_d;
      s3_dtspan_q <= s2_dtspan_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic               s4_vld_q;
  ctl_t               s4_ctl_q;
  logic [55:0]        s4_sq_q;
  logic [42:0]        s4_fs_q;
  logic signed [33:0] s4_dtspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_ctl_q    <= s3_ctl_q;
      s4_sq_q     <= {28'b0, s3_sc_q} * {28'b0, s3_sc_q};
      s4_fs_q     <= {15'b0, s3_sc_q} * {28'b0, Q16_POINT3};
      s4_dtspan_q <= s3_dtspan_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [15:0]        lo_sel, hi_sel;
  logic signed [16:0] span;
  logic signed [28:0] factor;
  logic signed [57:0] cs_d;
  logic signed [62:0] num_d;

  always_comb begin
    lo_sel = (s4_ctl_q.mode == MODE_SPIN) ? spn_min_q : drv_min_q;
    hi_sel = (s4_ctl_q.mode == MODE_SPIN) ? spn_max_q : drv_max_q;
    span   = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
    factor = Q16_ONE - $signed({2'b0, s4_fs_q[42:16]});
    cs_d   = $signed({1'b0, s4_sq_q[55:16]}) * span;
    num_d  = s4_dtspan_q * factor;
  end

  logic               s5_vld_q;
  ctl_t               s5_ctl_q;
  logic signed [57:0] s5_cs_q;
  logic signed [62:0] s5_num_q;
  logic [15:0]        s5_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_ctl_q <= s4_ctl_q;
      s5_cs_q  <= cs_d;
      s5_num_q <= num_d;
      s5_lo_q  <= lo_sel;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // both shifts truncate toward zero
  logic [57:0]        cs_mag;
  logic signed [47:0] cs_t;
  logic signed [47:0] base_d;
  logic [62:0]        num_mag;
  div_t               dv0_d;

  always_comb begin
    cs_mag  = s5_cs_q[57] ? 58'(-s5_cs_q) : 58'(s5_cs_q);
    cs_t    = s5_cs_q[57] ? -$signed({6'b0, cs_mag[57:16]}) : $signed({6'b0, cs_mag[57:16]});
    base_d  = cs_t + $signed({32'b0, s5_lo_q});
    num_mag = s5_num_q[62] ? 63'(-s5_num_q) : 63'(s5_num_q);
    dv0_d.rem  = '0;
    dv0_d.quo  = '0;
    dv0_d.dvd  = {1'b0, num_mag[62:16]};
    dv0_d.base = base_d;
    dv0_d.neg  = s5_num_q[62];
    dv0_d.ctl  = s5_ctl_q;
  end

  div_t               dv_q   [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv0_d;
    end
  end

  // ---------------------------------------------------------------- divider
  // offset magnitude / TURN_CENTER, one 16 bit digit per pair of stages
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [30:0] n_d;
    logic [63:0] est_prod;
    logic [30:0] n_q;
    logic [15:0] est_q;
    div_t        mid_q;
    logic        mid_vld_q;
    logic [31:0] rem_full;
    logic [16:0] rem_c;
    logic        geq;
    div_t        nxt_d;

    assign n_d      = {dv_q[k].rem, dv_q[k].dvd[DVD_W-1-DIG_W*k -: DIG_W]};
    assign est_prod = {33'b0, n_d} * {31'b0, RecipT};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mid_vld_q <= 1'b0;
      end else if (adv) begin
        mid_vld_q <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        n_q   <= n_d;
        est_q <= est_prod[47:32];
        mid_q <= dv_q[k];
      end
    end

    always_comb begin
      rem_full = {1'b0, n_q} - ({16'b0, est_q} * {16'b0, CtrT});
      rem_c    = rem_full[16:0];
      geq      = rem_c >= {1'b0, CtrT};
      nxt_d    = mid_q;
      nxt_d.quo = {mid_q.quo[DVD_W-DIG_W-1:0], (geq ? est_q + 16'd1 : est_q)};
      nxt_d.rem = geq ? 15'(rem_c - {1'b0, CtrT}) : rem_c[14:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k+1] <= mid_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1] <= nxt_d;
      end
    end
  end

  // ---------------------------------------------------------------- output
  function automatic logic [15:0] clamp_top(input logic signed [47:0] v,
                                            input logic [15:0] top);
    logic [15:0] r;
    if (v > $signed({32'b0, top})) begin
      r = top;
    end else if (v < 48'sd0) begin
      r = '0;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  div_t               fin;
  logic signed [47:0] offset, sum_l, sum_r;
  logic [15:0]        duty_l, duty_r;

  assign fin = dv_q[DIV_STEPS];

  always_comb begin
    offset = fin.neg ? -$signed(fin.quo) : $signed(fin.quo);
    sum_l  = fin.base - offset;
    sum_r  = fin.base + offset;
    case (fin.ctl.mode)
      MODE_DRIVE: begin
        duty_l = clamp_top(sum_l, drv_max_q);
        duty_r = clamp_top(sum_r, drv_max_q);
      end
      MODE_SPIN: begin
        duty_l = clamp_top(fin.base, 16'hFFFF);
        duty_r = duty_l;
      end
      default: begin
        duty_l = '0;
        duty_r = '0;
      end
    endcase
  end

  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [1:0]             out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {4'b0, fin.ctl.rb, fin.ctl.ra, fin.ctl.lb, fin.ctl.la, duty_r, duty_l};
      out_user_q <= fin.ctl.mode;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

[design/jddm_checker.sv]
// jddm_checker: port-level assertions for the joystick differential drive mixer
// bound to the top level below; uses jddm_pkg

module jddm_checker
  import jddm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]             m_axis_tuser_o,
  input logic                   cfg_we_i,
  input logic [2:0]             cfg_idx_i,
  input logic [CFG_W-1:0]       cfg_wdata_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // an empty output register never blocks the input side
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // stop means all duties and bridge levels at zero
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == MODE_STOP) |-> (m_axis_tdata_o == '0))
    else $error("stop beat with non-zero drive");

  // bridge levels follow the mode: both sides equal when driving, crossed when
  // spinning, never both inputs of one bridge on
  a_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != MODE_STOP) |->
      (m_axis_tdata_o[32] != m_axis_tdata_o[33]) &&
      (m_axis_tdata_o[34] != m_axis_tdata_o[35]) &&
      ((m_axis_tuser_o == MODE_DRIVE) == (m_axis_tdata_o[32] == m_axis_tdata_o[34])))
    else $error("bridge levels do not match drive mode");

endmodule

bind joystick_differential_drive_mixer_top jddm_checker u_jddm_checker (.*);
